// ----- design/vkr_pkg.sv -----
// Shared constants, types and codes of the keyframe reducer.
package vkr_pkg;

    localparam int COORD_WIDTH = 24;
    localparam int TIME_WIDTH  = 16;
    localparam int THR_WIDTH   = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_IDX_W   = 1;
    localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
    localparam int SUM_WIDTH   = 2 * COORD_WIDTH + 2;
    localparam int DOT_WIDTH   = SUM_WIDTH + 1;
    localparam int DIGIT       = 16;
    localparam int MUL_WIDTH   = ((SUM_WIDTH + THR_WIDTH + DIGIT - 1) / DIGIT) * DIGIT;
    localparam int MUL_STEPS   = MUL_WIDTH / DIGIT;
    localparam int PROD_WIDTH  = 2 * MUL_WIDTH;
    localparam int FRAC_SHIFT  = 2 * THR_WIDTH;
    localparam int CMP_WIDTH   = 2 * SUM_WIDTH + FRAC_SHIFT;
    localparam int STEP_CNT_W  = $clog2(MUL_STEPS + 1);

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx REG_FILTER_EN = CFG_IDX_W'(0);
    localparam t_cfg_idx REG_THRESHOLD = CFG_IDX_W'(1);

    localparam logic [THR_WIDTH-1:0] THR_RESET = THR_WIDTH'(32768);

    typedef enum logic [3:0] {
        ST_IDLE, ST_DISPATCH, ST_FLUSH, ST_PASS, ST_MUL_START,
        ST_MUL_WAIT, ST_DECIDE, ST_KEEP, ST_TAIL
    } t_state;

    // products in the order they are formed
    typedef enum logic [3:0] {
        OP_T0, OP_L0, OP_A0, OP_T1, OP_L1, OP_A1, OP_T2, OP_L2, OP_A2,
        OP_XA, OP_YT, OP_ZL, OP_RZ
    } t_op;

    typedef enum logic {
        SRC_CUR, SRC_PEND
    } t_src;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] key_x;
        logic signed [COORD_WIDTH-1:0] key_y;
        logic signed [COORD_WIDTH-1:0] key_z;
        logic [TIME_WIDTH-1:0]         key_time;
        logic                          last_key;
    } t_in;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] out_x;
        logic signed [COORD_WIDTH-1:0] out_y;
        logic signed [COORD_WIDTH-1:0] out_z;
        logic [TIME_WIDTH-1:0]         out_time;
        logic                          out_last;
    } t_out;

    typedef struct packed {
        logic load_cur;
        logic acc_clear;
        logic mul_start;
        logic capture;
        t_op  op;
        logic out_load;
        t_src out_sel;
        logic anc_from_cur;
        logic anc_from_pend;
        logic pend_from_cur;
    } t_cmd;

    typedef struct packed {
        logic filter_en;
        logic cur_last;
        logic mul_busy;
        logic mul_done;
        logic out_free;
        logic drop;
    } t_sts;

endpackage

// ----- design/vector_keyframe_reducer.sv -----
// Top level of the keyframe reducer: controller, datapath and configuration port.
//
// Input channel (i_in_valid / o_in_ready / i_in_data) takes one 3-D key per transfer;
// output channel (o_out_valid / i_out_ready / o_out_data) returns the kept keys in order,
// zero, one or two per input key, the final key of a track flagged with out_last.
// Configuration (i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data) is always ready;
// write index 0 for filter_enable, index 1 for error_threshold, only while idle.
// One key is worked at a time. A key that passes straight through (filter off or first
// of a track) is loaded into the output register without products. A key judged against a
// pending key takes 13 products on one shared shift-add multiplier that retires one
// 16-bit digit per cycle; the pending key is then dropped, or kept and sent out.
// Ready returns once the previous key's results sit in the output register; a stalled
// receiver holds the block in its emit step until the held result is transferred.
// Reset (synchronous, active low) clears both valid keys, empties the output register,
// enables the filter and sets the threshold to one half.
module vector_keyframe_reducer (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  vkr_pkg::t_in                   i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output vkr_pkg::t_out                  o_out_data,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  vkr_pkg::t_cfg_idx              i_cfg_index,
    input  logic [vkr_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    vkr_pkg::t_cmd w_cmd;
    vkr_pkg::t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    vkr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd),
        .i_sts      (w_sts)
    );

    vkr_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts)
    );

endmodule

// ----- design/vkr_mul.sv -----
// Shift-add multiplier, one 16-bit digit of the multiplier per cycle.
module vkr_mul (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [vkr_pkg::MUL_WIDTH-1:0]    i_a,
    input  logic [vkr_pkg::MUL_WIDTH-1:0]    i_b,
    output logic                             o_busy,
    output logic                             o_done,
    output logic [vkr_pkg::PROD_WIDTH-1:0]   o_prod
);

    logic [vkr_pkg::MUL_WIDTH-1:0]                r_a;
    logic [vkr_pkg::MUL_WIDTH-1:0]                r_b;
    logic [vkr_pkg::MUL_WIDTH-1:0]                r_hi;
    logic [vkr_pkg::MUL_WIDTH-1:0]                r_lo;
    logic [vkr_pkg::STEP_CNT_W-1:0]               r_cnt;
    logic                                         r_busy;
    logic                                         r_done;
    logic [vkr_pkg::MUL_WIDTH+vkr_pkg::DIGIT-1:0] w_pp;
    logic [vkr_pkg::MUL_WIDTH+vkr_pkg::DIGIT-1:0] w_sum;

    assign w_pp  = r_a * r_b[vkr_pkg::DIGIT-1:0];
    assign w_sum = w_pp + (vkr_pkg::MUL_WIDTH + vkr_pkg::DIGIT)'(r_hi);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= vkr_pkg::STEP_CNT_W'(vkr_pkg::MUL_STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == vkr_pkg::STEP_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // low digits retire into r_lo as the partial sum moves down
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a  <= i_a;
            r_b  <= i_b;
            r_hi <= '0;
            r_lo <= '0;
        end else if (r_busy) begin
            r_lo <= {w_sum[vkr_pkg::DIGIT-1:0], r_lo[vkr_pkg::MUL_WIDTH-1:vkr_pkg::DIGIT]};
            r_hi <= w_sum[vkr_pkg::MUL_WIDTH+vkr_pkg::DIGIT-1:vkr_pkg::DIGIT];
            r_b  <= r_b >> vkr_pkg::DIGIT;
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_prod = {r_hi, r_lo};

endmodule

// ----- design/vkr_dp.sv -----
// Datapath: key registers, configuration, dot-product accumulators, test and output register.
module vkr_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  vkr_pkg::t_in                   i_in_data,
    input  logic                           i_cfg_valid,
    input  vkr_pkg::t_cfg_idx              i_cfg_index,
    input  logic [vkr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_out_ready,
    output logic                           o_out_valid,
    output vkr_pkg::t_out                  o_out_data,
    input  vkr_pkg::t_cmd                  i_cmd,
    output vkr_pkg::t_sts                  o_sts
);

    localparam int CW = vkr_pkg::COORD_WIDTH;
    localparam int DW = vkr_pkg::DIFF_WIDTH;
    localparam int SW = vkr_pkg::SUM_WIDTH;
    localparam int MW = vkr_pkg::MUL_WIDTH;

    logic                            r_filter_en;
    logic [vkr_pkg::THR_WIDTH-1:0]   r_thr;
    logic signed [CW-1:0]            r_cur_pos [3];
    logic [vkr_pkg::TIME_WIDTH-1:0]  r_cur_time;
    logic                            r_cur_last;
    logic signed [CW-1:0]            r_anc_pos [3];
    logic signed [CW-1:0]            r_pend_pos [3];
    logic [vkr_pkg::TIME_WIDTH-1:0]  r_pend_time;
    logic signed [vkr_pkg::DOT_WIDTH-1:0] r_dot;
    logic [SW-1:0]                   r_len2;
    logic [SW-1:0]                   r_a2;
    logic [2*SW-1:0]                 r_diff;
    logic [MW-1:0]                   r_z;
    logic [vkr_pkg::CMP_WIDTH-1:0]   r_rhs;
    logic                            r_neg;
    logic                            r_out_valid;
    vkr_pkg::t_out                   r_out;

    logic [1:0]                      w_comp;
    logic signed [DW-1:0]            w_da;
    logic signed [DW-1:0]            w_dp;
    logic [DW-1:0]                   w_da_mag;
    logic [DW-1:0]                   w_dp_mag;
    logic [MW-1:0]                   w_mul_a;
    logic [MW-1:0]                   w_mul_b;
    logic                            w_mul_busy;
    logic                            w_mul_done;
    logic [vkr_pkg::PROD_WIDTH-1:0]  w_prod;
    logic [SW-1:0]                   w_prod_s;
    logic                            w_zero_len;
    logic                            w_a_zero;
    logic                            w_outside;
    logic                            w_fit;
    logic                            w_out_free;

    always_comb begin
        case (i_cmd.op) inside
            vkr_pkg::OP_T1, vkr_pkg::OP_L1, vkr_pkg::OP_A1: w_comp = 2'd1;
            vkr_pkg::OP_T2, vkr_pkg::OP_L2, vkr_pkg::OP_A2: w_comp = 2'd2;
            default:                                         w_comp = 2'd0;
        endcase
    end

    assign w_da = {r_pend_pos[w_comp][CW-1], r_pend_pos[w_comp]}
                - {r_anc_pos[w_comp][CW-1], r_anc_pos[w_comp]};
    assign w_dp = {r_cur_pos[w_comp][CW-1], r_cur_pos[w_comp]}
                - {r_anc_pos[w_comp][CW-1], r_anc_pos[w_comp]};
    assign w_da_mag = w_da[DW-1] ? DW'(-w_da) : DW'(w_da);
    assign w_dp_mag = w_dp[DW-1] ? DW'(-w_dp) : DW'(w_dp);

    always_comb begin
        case (i_cmd.op) inside
            vkr_pkg::OP_T0, vkr_pkg::OP_T1, vkr_pkg::OP_T2: begin
                w_mul_a = MW'(w_da_mag);
                w_mul_b = MW'(w_dp_mag);
            end
            vkr_pkg::OP_L0, vkr_pkg::OP_L1, vkr_pkg::OP_L2: begin
                w_mul_a = MW'(w_dp_mag);
                w_mul_b = MW'(w_dp_mag);
            end
            vkr_pkg::OP_A0, vkr_pkg::OP_A1, vkr_pkg::OP_A2: begin
                w_mul_a = MW'(w_da_mag);
                w_mul_b = MW'(w_da_mag);
            end
            vkr_pkg::OP_XA: begin
                w_mul_a = MW'(r_a2);
                w_mul_b = MW'(r_len2);
            end
            vkr_pkg::OP_YT: begin
                w_mul_a = MW'(r_dot[SW-1:0]);
                w_mul_b = MW'(r_dot[SW-1:0]);
            end
            vkr_pkg::OP_ZL: begin
                w_mul_a = MW'(r_len2);
                w_mul_b = MW'(r_thr);
            end
            vkr_pkg::OP_RZ: begin
                w_mul_a = r_z;
                w_mul_b = r_z;
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    vkr_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mul_start),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_busy  (w_mul_busy),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    assign w_prod_s = w_prod[SW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_en <= 1'b1;
            r_thr       <= vkr_pkg::THR_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                vkr_pkg::REG_FILTER_EN: r_filter_en <= i_cfg_data[0];
                vkr_pkg::REG_THRESHOLD: r_thr <= i_cfg_data[vkr_pkg::THR_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_cur) begin
            r_cur_pos[0] <= i_in_data.key_x;
            r_cur_pos[1] <= i_in_data.key_y;
            r_cur_pos[2] <= i_in_data.key_z;
            r_cur_time   <= i_in_data.key_time;
            r_cur_last   <= i_in_data.last_key;
        end
        if (i_cmd.anc_from_cur) begin
            r_anc_pos <= r_cur_pos;
        end else if (i_cmd.anc_from_pend) begin
            r_anc_pos <= r_pend_pos;
        end
        if (i_cmd.pend_from_cur) begin
            r_pend_pos  <= r_cur_pos;
            r_pend_time <= r_cur_time;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_start) begin
            r_neg <= w_da[DW-1] ^ w_dp[DW-1];
        end
        if (i_cmd.acc_clear) begin
            r_dot  <= '0;
            r_len2 <= '0;
            r_a2   <= '0;
        end else if (i_cmd.capture) begin
            case (i_cmd.op) inside
                vkr_pkg::OP_T0, vkr_pkg::OP_T1, vkr_pkg::OP_T2: begin
                    if (r_neg) begin
                        r_dot <= r_dot - $signed({1'b0, w_prod_s});
                    end else begin
                        r_dot <= r_dot + $signed({1'b0, w_prod_s});
                    end
                end
                vkr_pkg::OP_L0, vkr_pkg::OP_L1, vkr_pkg::OP_L2: r_len2 <= r_len2 + w_prod_s;
                vkr_pkg::OP_A0, vkr_pkg::OP_A1, vkr_pkg::OP_A2: r_a2 <= r_a2 + w_prod_s;
                vkr_pkg::OP_XA: r_diff <= w_prod[2*SW-1:0];
                vkr_pkg::OP_YT: r_diff <= r_diff - w_prod[2*SW-1:0];
                vkr_pkg::OP_ZL: r_z <= w_prod[MW-1:0];
                vkr_pkg::OP_RZ: r_rhs <= w_prod[vkr_pkg::CMP_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // squared distance test, scaled so the Q0.16 threshold lines up
    assign w_zero_len = (r_len2 == '0);
    assign w_a_zero   = (r_pend_pos[0] == r_anc_pos[0]) && (r_pend_pos[1] == r_anc_pos[1])
                     && (r_pend_pos[2] == r_anc_pos[2]);
    assign w_outside  = (r_dot < 0) || (r_dot > $signed({1'b0, r_len2}));
    assign w_fit      = {r_diff, vkr_pkg::FRAC_SHIFT'(0)} <= r_rhs;

    assign w_out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            if (i_cmd.out_sel == vkr_pkg::SRC_PEND) begin
                r_out.out_x    <= r_pend_pos[0];
                r_out.out_y    <= r_pend_pos[1];
                r_out.out_z    <= r_pend_pos[2];
                r_out.out_time <= r_pend_time;
                r_out.out_last <= 1'b0;
            end else begin
                r_out.out_x    <= r_cur_pos[0];
                r_out.out_y    <= r_cur_pos[1];
                r_out.out_z    <= r_cur_pos[2];
                r_out.out_time <= r_cur_time;
                r_out.out_last <= r_cur_last;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        o_sts.filter_en = r_filter_en;
        o_sts.cur_last  = r_cur_last;
        o_sts.mul_busy  = w_mul_busy;
        o_sts.mul_done  = w_mul_done;
        o_sts.out_free  = w_out_free;
        o_sts.drop      = w_zero_len ? w_a_zero : (!w_outside && w_fit);
    end

endmodule

// ----- design/vkr_ctrl.sv -----
// Controller: sequences the products, the keep-or-drop decision and the transfers out.
module vkr_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output vkr_pkg::t_cmd o_cmd,
    input  vkr_pkg::t_sts i_sts
);

    vkr_pkg::t_state r_state, n_state;
    vkr_pkg::t_op    r_op, n_op;
    logic            r_have_anc, n_have_anc;
    logic            r_have_pend, n_have_pend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= vkr_pkg::ST_IDLE;
            r_op        <= vkr_pkg::OP_T0;
            r_have_anc  <= 1'b0;
            r_have_pend <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_op        <= n_op;
            r_have_anc  <= n_have_anc;
            r_have_pend <= n_have_pend;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_have_anc  = r_have_anc;
        n_have_pend = r_have_pend;
        o_in_ready  = 1'b0;
        o_cmd       = '0;
        o_cmd.op    = r_op;
        unique case (r_state)
            vkr_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_cur = 1'b1;
                    n_state        = vkr_pkg::ST_DISPATCH;
                end
            end
            vkr_pkg::ST_DISPATCH: begin
                if (!i_sts.filter_en || !r_have_anc) begin
                    n_state = (r_have_anc && r_have_pend) ? vkr_pkg::ST_FLUSH
                                                          : vkr_pkg::ST_PASS;
                end else if (r_have_pend) begin
                    o_cmd.acc_clear = 1'b1;
                    n_op            = vkr_pkg::OP_T0;
                    n_state         = vkr_pkg::ST_MUL_START;
                end else begin
                    n_state = vkr_pkg::ST_TAIL;
                end
            end
            vkr_pkg::ST_FLUSH: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = vkr_pkg::SRC_PEND;
                    n_state        = vkr_pkg::ST_PASS;
                end
            end
            vkr_pkg::ST_PASS: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load     = 1'b1;
                    o_cmd.out_sel      = vkr_pkg::SRC_CUR;
                    o_cmd.anc_from_cur = 1'b1;
                    n_have_anc         = !i_sts.cur_last;
                    n_have_pend        = 1'b0;
                    n_state            = vkr_pkg::ST_IDLE;
                end
            end
            vkr_pkg::ST_MUL_START: begin
                o_cmd.mul_start = 1'b1;
                n_state         = vkr_pkg::ST_MUL_WAIT;
            end
            vkr_pkg::ST_MUL_WAIT: begin
                if (i_sts.mul_done) begin
                    o_cmd.capture = 1'b1;
                    if (r_op == vkr_pkg::OP_RZ) begin
                        n_state = vkr_pkg::ST_DECIDE;
                    end else begin
                        n_op    = vkr_pkg::t_op'(r_op + 4'd1);
                        n_state = vkr_pkg::ST_MUL_START;
                    end
                end
            end
            vkr_pkg::ST_DECIDE: begin
                n_have_pend = 1'b0;
                n_state     = i_sts.drop ? vkr_pkg::ST_TAIL : vkr_pkg::ST_KEEP;
            end
            vkr_pkg::ST_KEEP: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load      = 1'b1;
                    o_cmd.out_sel       = vkr_pkg::SRC_PEND;
                    o_cmd.anc_from_pend = 1'b1;
                    n_state             = vkr_pkg::ST_TAIL;
                end
            end
            vkr_pkg::ST_TAIL: begin
                if (i_sts.cur_last) begin
                    if (i_sts.out_free) begin
                        o_cmd.out_load = 1'b1;
                        o_cmd.out_sel  = vkr_pkg::SRC_CUR;
                        n_have_anc     = 1'b0;
                        n_have_pend    = 1'b0;
                        n_state        = vkr_pkg::ST_IDLE;
                    end
                end else begin
                    o_cmd.pend_from_cur = 1'b1;
                    n_have_pend         = 1'b1;
                    n_state             = vkr_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = vkr_pkg::ST_IDLE;
            end
        endcase
    end

    a_start_idle_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.mul_start |-> !i_sts.mul_busy)
        else $error("multiplier started while busy");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> i_sts.out_free)
        else $error("output register overwritten before transfer");

    a_pend_needs_anc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_have_pend |-> r_have_anc)
        else $error("pending key held without an anchor");

    a_accept_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == vkr_pkg::ST_DISPATCH))
        else $error("accepted key not dispatched");

endmodule
